/* design/ipcs_pkg.sv */
package ipcs_pkg;

  localparam int CHANNELS   = 8;
  localparam int PAIRS      = 4;
  localparam int SAMPLE_W   = 12;
  localparam int PERIOD_W   = 12;
  localparam int WAIT_W     = 6;
  localparam int SKIP_W     = 10;
  localparam int IDX_W      = 8;
  localparam int CHAN_SEL_W = 3;
  localparam int PAIR_SEL_W = 2;
  localparam int PAIR_CNT_W = 3;
  localparam int FRAME_W    = IDX_W - CHAN_SEL_W;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // stream payload layout
  localparam int IN_TDATA_W  = 120;
  localparam int IN_TUSER_W  = 2;
  localparam int SKIP_LSB    = CHANNELS * SAMPLE_W;
  localparam int IDX_LSB     = SKIP_LSB + SKIP_W;
  localparam int OUT_TDATA_W = 72;

  localparam logic [PERIOD_W-1:0] PROX_PERIOD_RST  = 12'd2460;
  localparam logic [WAIT_W-1:0]   AMBIENT_WAIT_RST = 6'd26;
  localparam logic [WAIT_W-1:0]   PULSE_WAIT_RST   = 6'd4;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_SKIP  = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_PROX_ENABLE  = 3'd0,
    REG_COMM_ENABLE  = 3'd1,
    REG_PROX_PERIOD  = 3'd2,
    REG_AMBIENT_WAIT = 3'd3,
    REG_PULSE_WAIT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                prox_enable;
    logic                comm_enable;
    logic [PERIOD_W-1:0] prox_period;
    logic [WAIT_W-1:0]   ambient_wait;
    logic [WAIT_W-1:0]   pulse_wait;
  } cfg_t;

  typedef struct packed {
    logic [PAIRS-1:0]      pulse_lines;
    logic                  prox_mode;
    logic                  window_ready;
    logic                  prox_update;
    logic                  prox_reflected_phase;
    logic [PAIR_SEL_W-1:0] prox_pair;
    sample_t               ambient_first;
    sample_t               ambient_second;
    sample_t               delta_first;
    sample_t               delta_second;
  } result_t;

endpackage

/* design/ir_prox_and_comm_adc_sequencer.sv */
// ADC frame sequencer for IR proximity sensing and optical communication. One
// request enters per clock while s_tready is high (s_tuser carries the action:
// frame, skip or window read) and each request produces exactly one result beat
// on the master side. A result waits in a pipe stage for the registered read
// port of the window memory, then in the output register. The memory is split
// into eight channel banks so a whole frame is written at once. Each bank holds
// both halves of the double-buffered window (RAM_DEPTH words, twice
// WINDOW_FRAMES rounded up to a power of two); frames go to the sampling half
// and reads return words of the completed half, word index = frame*8 + channel.
// Words of the completed half that were never written read back as garbage, and
// there is no clearing pass after reset. Proximity sequencing (ambient capture,
// emitter pulse, reflected capture per sensor pair) and the period/skip counters
// are updated in the acceptance cycle, so back-to-back requests see each other's
// effects. Configuration is an APB slave; change it only while the block idles.
module ir_prox_and_comm_adc_sequencer #(
  parameter int WINDOW_FRAMES = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // slave stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // sample_ch0..sample_ch7 (12 bits each), skip_count (10), read_index (8), zero pad
  input  logic [ipcs_pkg::IN_TDATA_W-1:0]        s_tdata,
  // action (2)
  input  logic [ipcs_pkg::IN_TUSER_W-1:0]        s_tuser,
  // master stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // pulse_lines (4), prox_mode, window_ready, prox_update, prox_reflected_phase,
  // prox_pair (2), ambient_first, ambient_second, delta_first, delta_second,
  // read_data (12 each), zero pad
  output logic [ipcs_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ipcs_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [ipcs_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [ipcs_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int SLOT_W    = $clog2(WINDOW_FRAMES);
  localparam int RAM_DEPTH = 2 << SLOT_W;
  localparam int EXT_W     = SLOT_W + ipcs_pkg::FRAME_W;

  ipcs_pkg::cfg_t    cfg;
  ipcs_pkg::result_t res;

  // request decode
  logic                                       accept;
  ipcs_pkg::action_t                          action;
  ipcs_pkg::sample_t [ipcs_pkg::CHANNELS-1:0] samples;
  logic [ipcs_pkg::SKIP_W-1:0]                skip_count;
  logic [ipcs_pkg::IDX_W-1:0]                 read_index;

  assign accept     = s_tvalid && s_tready;
  assign action     = ipcs_pkg::action_t'(s_tuser);
  assign skip_count = s_tdata[ipcs_pkg::SKIP_LSB +: ipcs_pkg::SKIP_W];
  assign read_index = s_tdata[ipcs_pkg::IDX_LSB +: ipcs_pkg::IDX_W];

  always_comb begin
    for (int c = 0; c < ipcs_pkg::CHANNELS; c++) begin
      samples[c] = s_tdata[c*ipcs_pkg::SAMPLE_W +: ipcs_pkg::SAMPLE_W];
    end
  end

  ipcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer state and window write control
  logic              win_we;
  logic [SLOT_W:0]   win_addr;
  logic              buffer_select;

  ipcs_ctrl #(
    .WINDOW_FRAMES (WINDOW_FRAMES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .step          (accept),
    .action        (action),
    .samples       (samples),
    .skip_count    (skip_count),
    .cfg           (cfg),
    .res           (res),
    .win_we        (win_we),
    .win_addr      (win_addr),
    .buffer_select (buffer_select)
  );

  // window read: frame selects the bank row, channel selects the bank
  logic [ipcs_pkg::FRAME_W-1:0]    rd_frame;
  logic [EXT_W-1:0]                rd_frame_ext;
  logic [ipcs_pkg::CHAN_SEL_W-1:0] rd_chan;
  logic                            rd_in_range;
  logic                            rd_en;
  logic [SLOT_W:0]                 rd_addr;

  assign rd_frame     = read_index[ipcs_pkg::IDX_W-1:ipcs_pkg::CHAN_SEL_W];
  assign rd_frame_ext = EXT_W'(rd_frame);
  assign rd_chan      = read_index[ipcs_pkg::CHAN_SEL_W-1:0];
  assign rd_in_range  = 32'(rd_frame) < 32'(WINDOW_FRAMES);
  assign rd_en        = accept && (action == ipcs_pkg::ACT_READ);
  // read the completed half, the one not being filled
  assign rd_addr      = {~buffer_select, rd_frame_ext[SLOT_W-1:0]};

  ipcs_pkg::sample_t bank_rdata [ipcs_pkg::CHANNELS];

  for (genvar c = 0; c < ipcs_pkg::CHANNELS; c++) begin : g_bank
    ipcs_ram #(
      .WIDTH (ipcs_pkg::SAMPLE_W),
      .DEPTH (RAM_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (win_we),
      .waddr (win_addr),
      .wdata (samples[c]),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (bank_rdata[c])
    );
  end

  // pipe stage waits for the bank read; the bank holds its data while stalled
  logic                            p_valid;
  ipcs_pkg::result_t               p_res;
  logic                            p_rd;
  logic [ipcs_pkg::CHAN_SEL_W-1:0] p_chan;
  logic                            p_adv;
  ipcs_pkg::sample_t               read_data;

  // output register
  logic                            o_valid;
  logic [ipcs_pkg::OUT_TDATA_W-1:0] o_tdata;

  assign p_adv     = p_valid && (!o_valid || m_tready);
  assign s_tready  = !p_valid || !o_valid || m_tready;
  assign read_data = p_rd ? bank_rdata[p_chan] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (accept) begin
        p_valid <= 1'b1;
      end else if (p_adv) begin
        p_valid <= 1'b0;
      end
      if (p_adv) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_res  <= res;
      p_rd   <= rd_en && rd_in_range;
      p_chan <= rd_chan;
    end
    if (p_adv) begin
      o_tdata <= {2'b00, read_data,
                  p_res.delta_second, p_res.delta_first,
                  p_res.ambient_second, p_res.ambient_first,
                  p_res.prox_pair, p_res.prox_reflected_phase,
                  p_res.prox_update, p_res.window_ready,
                  p_res.prox_mode, p_res.pulse_lines};
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_tdata;

endmodule

/* design/ipcs_ram.sv */
module ipcs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/ipcs_regs.sv */
module ipcs_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ipcs_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ipcs_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ipcs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output ipcs_pkg::cfg_t                      cfg
);

  ipcs_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  assign reg_idx = ipcs_pkg::reg_idx_t'(paddr[ipcs_pkg::CFG_ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prox_enable  <= 1'b1;
      cfg.comm_enable  <= 1'b1;
      cfg.prox_period  <= ipcs_pkg::PROX_PERIOD_RST;
      cfg.ambient_wait <= ipcs_pkg::AMBIENT_WAIT_RST;
      cfg.pulse_wait   <= ipcs_pkg::PULSE_WAIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        ipcs_pkg::REG_PROX_ENABLE:  cfg.prox_enable  <= pwdata[0];
        ipcs_pkg::REG_COMM_ENABLE:  cfg.comm_enable  <= pwdata[0];
        ipcs_pkg::REG_PROX_PERIOD:  cfg.prox_period  <= pwdata[ipcs_pkg::PERIOD_W-1:0];
        ipcs_pkg::REG_AMBIENT_WAIT: cfg.ambient_wait <= pwdata[ipcs_pkg::WAIT_W-1:0];
        ipcs_pkg::REG_PULSE_WAIT:   cfg.pulse_wait   <= pwdata[ipcs_pkg::WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      ipcs_pkg::REG_PROX_ENABLE:  prdata[0] = cfg.prox_enable;
      ipcs_pkg::REG_COMM_ENABLE:  prdata[0] = cfg.comm_enable;
      ipcs_pkg::REG_PROX_PERIOD:  prdata[ipcs_pkg::PERIOD_W-1:0] = cfg.prox_period;
      ipcs_pkg::REG_AMBIENT_WAIT: prdata[ipcs_pkg::WAIT_W-1:0] = cfg.ambient_wait;
      ipcs_pkg::REG_PULSE_WAIT:   prdata[ipcs_pkg::WAIT_W-1:0] = cfg.pulse_wait;
      default: prdata = '0;
    endcase
  end

endmodule

/* design/ipcs_ctrl.sv */
module ipcs_ctrl #(
  parameter int WINDOW_FRAMES = 32
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                step,
  input  ipcs_pkg::action_t                                   action,
  input  ipcs_pkg::sample_t [ipcs_pkg::CHANNELS-1:0]          samples,
  input  logic [ipcs_pkg::SKIP_W-1:0]                         skip_count,
  input  ipcs_pkg::cfg_t                                      cfg,
  output ipcs_pkg::result_t                                   res,
  output logic                                                win_we,
  output logic [$clog2(WINDOW_FRAMES):0]                      win_addr,
  output logic                                                buffer_select
);

  localparam int SLOT_W = $clog2(WINDOW_FRAMES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_FRAMES - 1);

  // sequencer state
  logic [ipcs_pkg::PERIOD_W-1:0]   period_count, period_count_next;
  logic                            mode_flag, mode_flag_next;
  logic [ipcs_pkg::WAIT_W-1:0]     wait_count, wait_count_next;
  logic [ipcs_pkg::WAIT_W-1:0]     wait_limit, wait_limit_next;
  logic [ipcs_pkg::PAIR_CNT_W-1:0] pair_index, pair_index_next;
  logic                            capture_phase, capture_phase_next;
  logic [ipcs_pkg::PAIRS-1:0]      emitter_state, emitter_state_next;
  logic [ipcs_pkg::SKIP_W-1:0]     skip_remaining, skip_remaining_next;
  logic [SLOT_W-1:0]               frame_slot, frame_slot_next;
  logic                            buffer_select_next;

  // per-pair capture stores, one entry per pair
  ipcs_pkg::sample_t amb_first  [ipcs_pkg::PAIRS];
  ipcs_pkg::sample_t amb_second [ipcs_pkg::PAIRS];
  ipcs_pkg::sample_t dlt_first  [ipcs_pkg::PAIRS];
  ipcs_pkg::sample_t dlt_second [ipcs_pkg::PAIRS];

  logic                            amb_we, dlt_we;
  logic [ipcs_pkg::PAIR_SEL_W-1:0] k;
  ipcs_pkg::sample_t               s_first, s_second, d_first, d_second;

  always_comb begin
    period_count_next   = period_count;
    mode_flag_next      = mode_flag;
    wait_count_next     = wait_count;
    wait_limit_next     = wait_limit;
    pair_index_next     = pair_index;
    capture_phase_next  = capture_phase;
    emitter_state_next  = emitter_state;
    skip_remaining_next = skip_remaining;
    frame_slot_next     = frame_slot;
    buffer_select_next  = buffer_select;
    res                 = '0;
    win_we              = 1'b0;
    win_addr            = {buffer_select, frame_slot};
    amb_we              = 1'b0;
    dlt_we              = 1'b0;
    k                   = pair_index_next[ipcs_pkg::PAIR_SEL_W-1:0];
    s_first             = samples[{1'b0, k}];
    s_second            = samples[{1'b1, k}];
    d_first             = (s_first > amb_first[k]) ? '0 : amb_first[k] - s_first;
    d_second            = (s_second > amb_second[k]) ? '0 : amb_second[k] - s_second;

    if (step) begin
      case (action)
        ipcs_pkg::ACT_FRAME: begin
          if (cfg.prox_enable) begin
            period_count_next = period_count + 1'b1;
          end
          // period reached: restart the proximity sequence from pair 0
          if (period_count_next >= cfg.prox_period) begin
            period_count_next  = '0;
            emitter_state_next = '0;
            wait_count_next    = '0;
            wait_limit_next    = cfg.ambient_wait;
            capture_phase_next = 1'b0;
            pair_index_next    = '0;
            mode_flag_next     = 1'b1;
          end
          k        = pair_index_next[ipcs_pkg::PAIR_SEL_W-1:0];
          s_first  = samples[{1'b0, k}];
          s_second = samples[{1'b1, k}];
          d_first  = (s_first > amb_first[k]) ? '0 : amb_first[k] - s_first;
          d_second = (s_second > amb_second[k]) ? '0 : amb_second[k] - s_second;
          if (!mode_flag_next) begin
            if (cfg.comm_enable) begin
              if (skip_remaining != '0) begin
                skip_remaining_next = skip_remaining - 1'b1;
              end else begin
                win_we = 1'b1;
                if (frame_slot == LAST_SLOT) begin
                  frame_slot_next    = '0;
                  res.window_ready   = 1'b1;
                  buffer_select_next = ~buffer_select;
                end else begin
                  frame_slot_next = frame_slot + 1'b1;
                end
              end
            end
          end else begin
            wait_count_next = wait_count_next + 1'b1;
            if (wait_count_next >= wait_limit_next) begin
              wait_count_next = '0;
              if (pair_index_next[ipcs_pkg::PAIR_CNT_W-1]) begin
                frame_slot_next = '0;
                mode_flag_next  = 1'b0;
              end else begin
                res.prox_update = 1'b1;
                res.prox_pair   = k;
                if (!capture_phase_next) begin
                  amb_we                = 1'b1;
                  emitter_state_next[k] = 1'b1;
                  capture_phase_next    = 1'b1;
                  wait_limit_next       = cfg.pulse_wait;
                  res.ambient_first     = s_first;
                  res.ambient_second    = s_second;
                  res.delta_first       = dlt_first[k];
                  res.delta_second      = dlt_second[k];
                end else begin
                  dlt_we                   = 1'b1;
                  emitter_state_next[k]    = 1'b0;
                  capture_phase_next       = 1'b0;
                  pair_index_next          = pair_index_next + 1'b1;
                  wait_limit_next          = cfg.ambient_wait;
                  res.prox_reflected_phase = 1'b1;
                  res.ambient_first        = amb_first[k];
                  res.ambient_second       = amb_second[k];
                  res.delta_first          = d_first;
                  res.delta_second         = d_second;
                end
              end
            end
          end
        end
        ipcs_pkg::ACT_SKIP: begin
          skip_remaining_next = skip_count;
          frame_slot_next     = '0;
        end
        default: ;
      endcase
    end

    res.pulse_lines = emitter_state_next;
    res.prox_mode   = mode_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count   <= '0;
      mode_flag      <= 1'b0;
      wait_count     <= '0;
      wait_limit     <= '0;
      pair_index     <= '0;
      capture_phase  <= 1'b0;
      emitter_state  <= '0;
      skip_remaining <= '0;
      frame_slot     <= '0;
      buffer_select  <= 1'b0;
      for (int i = 0; i < ipcs_pkg::PAIRS; i++) begin
        amb_first[i]  <= '0;
        amb_second[i] <= '0;
        dlt_first[i]  <= '0;
        dlt_second[i] <= '0;
      end
    end else begin
      period_count   <= period_count_next;
      mode_flag      <= mode_flag_next;
      wait_count     <= wait_count_next;
      wait_limit     <= wait_limit_next;
      pair_index     <= pair_index_next;
      capture_phase  <= capture_phase_next;
      emitter_state  <= emitter_state_next;
      skip_remaining <= skip_remaining_next;
      frame_slot     <= frame_slot_next;
      buffer_select  <= buffer_select_next;
      if (amb_we) begin
        amb_first[k]  <= s_first;
        amb_second[k] <= s_second;
      end
      if (dlt_we) begin
        dlt_first[k]  <= d_first;
        dlt_second[k] <= d_second;
      end
    end
  end

endmodule

/* design/ipcs_checker.sv */
module ipcs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ipcs_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic ready_bit, upd_bit, refl_bit;
  logic [ipcs_pkg::SAMPLE_W-1:0] rdata;

  assign ready_bit = m_tdata[5];
  assign upd_bit   = m_tdata[6];
  assign refl_bit  = m_tdata[7];
  assign rdata     = m_tdata[69:58];

  // no result left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // window completion and proximity capture come from different modes
  a_mode_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(ready_bit && upd_bit))
    else $error("window_ready and prox_update together");

  a_refl_upd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && refl_bit |-> upd_bit)
    else $error("reflected phase without capture");

  a_read_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (rdata != '0) |-> !ready_bit && !upd_bit)
    else $error("read data on a frame result");

endmodule

bind ir_prox_and_comm_adc_sequencer ipcs_checker u_ipcs_checker (.*);
